/* sv/jac_pkg.sv */
package jac_pkg;

	// fixed-point constants
	localparam int FULL_SCALE = 32768;
	localparam int NUM_AX     = 3;
	localparam int PADDR_W    = 5;
	localparam int MUL_AW     = 26;
	localparam int MUL_BW     = 18;
	localparam int PROD_W     = MUL_AW + MUL_BW;

	// register reset values
	localparam logic [14:0] DEADBAND_RST = 15'd3277;
	localparam logic [15:0] SLOPE_RST    = 16'd16384;
	localparam logic [15:0] SPEED_HI_RST = 16'd256;
	localparam logic [15:0] SPEED_LO_RST = 16'd128;

	// register indexes
	typedef enum logic [2:0] {
		REG_DEADBAND_XY,
		REG_SLOPE_XY,
		REG_DEADBAND_ROT,
		REG_SLOPE_ROT,
		REG_SPEED_XY_HIGH,
		REG_SPEED_XY_LOW,
		REG_SPEED_ROT_HIGH,
		REG_SPEED_ROT_LOW
	} reg_idx_t;

	// axis indexes inside one work item
	typedef logic [1:0] ax_idx_t;
	localparam ax_idx_t AX_X   = 2'd0;
	localparam ax_idx_t AX_Y   = 2'd1;
	localparam ax_idx_t AX_ROT = 2'd2;

	typedef struct packed {
		logic signed [15:0] axis_fore;
		logic signed [15:0] axis_side;
		logic signed [15:0] axis_throttle;
		logic signed [15:0] axis_twist;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] cmd_x;
		logic signed [23:0] cmd_y;
		logic signed [23:0] cmd_rot;
	} out_item_t;

	typedef struct packed {
		logic [14:0] deadband_xy;
		logic [15:0] slope_xy;
		logic [14:0] deadband_rot;
		logic [15:0] slope_rot;
		logic [15:0] speed_xy_high;
		logic [15:0] speed_xy_low;
		logic [15:0] speed_rot_high;
		logic [15:0] speed_rot_low;
	} cfg_t;

	// one classified axis: sign, inside deadband, magnitude above deadband
	typedef struct packed {
		logic        neg;
		logic        dead;
		logic [15:0] diff;
	} axis_t;

	typedef struct packed {
		axis_t [NUM_AX-1:0] ax;
		logic  [16:0]       k16;
	} work_t;

	typedef struct packed {
		logic        start;
		logic [15:0] diff;
		logic [15:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FXY,
		ST_FXY_W,
		ST_FROT,
		ST_FROT_W,
		ST_DIV,
		ST_DIV_W,
		ST_GAIN,
		ST_GAIN_W,
		ST_SHAPE,
		ST_SHAPE_W,
		ST_SCALE,
		ST_SCALE_W,
		ST_FILT,
		ST_FILT_W,
		ST_OUT
	} back_state_t;

endpackage

/* sv/jac_if.sv */
// input channel: four raw axes
interface jac_in_if;
	logic               valid;
	logic               ready;
	jac_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// output channel: three filtered commands
interface jac_out_if;
	logic               valid;
	logic               ready;
	jac_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* sv/jac_front.sv */
module jac_front (
	input  jac_pkg::cfg_t  cfg,
	jac_in_if.sink         in_ch,
	input  logic           q_full,
	output logic           push,
	output jac_pkg::work_t work
);
	import jac_pkg::*;

	// sign, deadband test and magnitude above deadband
	function automatic axis_t classify(input logic signed [16:0] r, input logic [14:0] d);
		axis_t       ax;
		logic [16:0] mag;
		logic [16:0] dz;
		dz = {2'b00, d};
		mag = r[16] ? 17'(-r) : 17'(r);
		ax.neg = r[16];
		ax.dead = (mag <= dz);
		ax.diff = 16'(mag - dz);
		return ax;
	endfunction

	logic signed [16:0] fore_ext;
	logic signed [16:0] rx;
	logic signed [16:0] side_ext;
	logic signed [16:0] twist_ext;
	logic signed [17:0] k_wide;

	// fore axis negated, most negative code saturates
	always_comb begin
		fore_ext = 17'(in_ch.data.axis_fore);
		side_ext = 17'(in_ch.data.axis_side);
		twist_ext = 17'(in_ch.data.axis_twist);
		if (in_ch.data.axis_fore == 16'sh8000) begin
			rx = 17'sd32767;
		end else begin
			rx = -fore_ext;
		end
		k_wide = 18'sd32768 - 18'(in_ch.data.axis_throttle);
	end

	// classify all axes into one work item
	always_comb begin
		work.ax[AX_X] = classify(rx, cfg.deadband_xy);
		work.ax[AX_Y] = classify(side_ext, cfg.deadband_xy);
		work.ax[AX_ROT] = classify(twist_ext, cfg.deadband_rot);
		work.k16 = k_wide[16:0];
	end

	// accept whenever the queue has room
	assign in_ch.ready = !q_full;
	assign push = in_ch.valid && !q_full;

endmodule

/* sv/jac_queue.sv */
module jac_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jac_pkg::work_t wr_data,
	input  logic           pop,
	output jac_pkg::work_t rd_data,
	output logic           full,
	output logic           empty
);
	import jac_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	work_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);

endmodule

/* sv/jac_div.sv */
module jac_div (
	input  logic              clk,
	input  logic              arst_n,
	input  jac_pkg::div_req_t req,
	output jac_pkg::div_rsp_t rsp
);
	import jac_pkg::*;

	// quotient diff * 2^15 / den, one bit a cycle
	localparam int STEPS = 16;
	localparam int CNT_W = $clog2(STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      rem_q;
	logic [15:0]      bits_q;
	logic [15:0]      den_q;
	logic [15:0]      quot_q;
	logic [16:0]      trial;
	logic             ge;
	logic [15:0]      rem_next;
	logic             last;

	// restoring step
	always_comb begin
		trial = {rem_q, bits_q[15]};
		ge = (trial >= {1'b0, den_q});
		if (ge) begin
			rem_next = 16'(trial - {1'b0, den_q});
		end else begin
			rem_next = trial[15:0];
		end
		last = (cnt_q == CNT_W'(STEPS - 1));
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// partial remainder and quotient; top of the dividend preloads the remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.diff[15:1]};
			bits_q <= {req.diff[0], 15'b0};
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_next;
			bits_q <= {bits_q[14:0], 1'b0};
			quot_q <= {quot_q[14:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

/* sv/jac_back.sv */
module jac_back #(
	parameter int FILTER_ALPHA_Q16 = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  jac_pkg::cfg_t  cfg,
	input  jac_pkg::work_t rd_data,
	input  logic           q_empty,
	output logic           pop,
	jac_out_if.source      out_ch
);
	import jac_pkg::*;

	localparam logic signed [MUL_BW-1:0] ALPHA_B = MUL_BW'(FILTER_ALPHA_Q16);

	// arithmetic shift right, rounding toward zero
	function automatic logic signed [PROD_W-1:0] shr_tz(
		input logic signed [PROD_W-1:0] v,
		input int unsigned              n
	);
		logic signed [PROD_W-1:0] bias;
		bias = v[PROD_W-1] ? ((PROD_W'(1) <<< n) - PROD_W'(1)) : '0;
		return (v + bias) >>> n;
	endfunction

	back_state_t               state_q;
	back_state_t               state_d;
	work_t                     work_q;
	ax_idx_t                   ax_q;
	logic [15:0]               fxy_q;
	logic [15:0]               frot_q;
	logic [15:0]               m_q;
	logic signed [16:0]        g_q;
	logic signed [16:0]        s_q;
	logic signed [23:0]        c_q;
	logic signed [23:0]        filt_q [NUM_AX];
	logic signed [PROD_W-1:0]  prod_q;
	logic                      out_valid_q;
	out_item_t                 out_data_q;

	axis_t                     cur_ax;
	logic [15:0]               cur_slope;
	logic [14:0]               cur_dband;
	logic [15:0]               cur_den;
	logic [15:0]               cur_f;
	logic signed [23:0]        cur_filt;
	logic                      last_ax;
	logic                      out_free;
	logic signed [MUL_AW-1:0]  mul_a;
	logic signed [MUL_BW-1:0]  mul_b;
	logic [16:0]               om;
	logic signed [24:0]        fdiff;
	logic [16:0]               fxy_sum;
	logic [16:0]               frot_sum;
	logic [15:0]               fxy_new;
	logic [15:0]               frot_new;
	logic signed [17:0]        g_wide;
	logic signed [PROD_W-1:0]  t_shape;
	logic signed [PROD_W-1:0]  t_scale;
	logic signed [PROD_W-1:0]  t_filt;
	logic signed [16:0]        s_new;
	logic signed [23:0]        c_new;
	logic signed [23:0]        filt_new;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	jac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// per-axis selection
	always_comb begin
		case (ax_q)
			AX_X: begin
				cur_ax = work_q.ax[AX_X];
				cur_filt = filt_q[AX_X];
			end
			AX_Y: begin
				cur_ax = work_q.ax[AX_Y];
				cur_filt = filt_q[AX_Y];
			end
			AX_ROT: begin
				cur_ax = work_q.ax[AX_ROT];
				cur_filt = filt_q[AX_ROT];
			end
			default: begin
				cur_ax = work_q.ax[AX_X];
				cur_filt = filt_q[AX_X];
			end
		endcase
		last_ax = (ax_q == AX_ROT);
		cur_slope = last_ax ? cfg.slope_rot : cfg.slope_xy;
		cur_dband = last_ax ? cfg.deadband_rot : cfg.deadband_xy;
		cur_f = last_ax ? frot_q : fxy_q;
		cur_den = 16'(17'(FULL_SCALE) - {2'b00, cur_dband});
		om = 17'(FULL_SCALE) - {1'b0, m_q};
		fdiff = 25'(c_q) - 25'(cur_filt);
		out_free = !out_valid_q || out_ch.ready;
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_FXY: begin
				mul_a = signed'({10'b0, 16'(cfg.speed_xy_high - cfg.speed_xy_low)});
				mul_b = signed'({1'b0, work_q.k16});
			end
			ST_FROT: begin
				mul_a = signed'({10'b0, 16'(cfg.speed_rot_high - cfg.speed_rot_low)});
				mul_b = signed'({1'b0, work_q.k16});
			end
			ST_GAIN: begin
				mul_a = signed'({10'b0, cur_slope});
				mul_b = signed'({1'b0, om});
			end
			ST_SHAPE: begin
				mul_a = MUL_AW'(g_q);
				mul_b = signed'({2'b00, m_q});
			end
			ST_SCALE: begin
				mul_a = MUL_AW'(s_q);
				mul_b = signed'({2'b00, cur_f});
			end
			ST_FILT: begin
				mul_a = MUL_AW'(fdiff);
				mul_b = ALPHA_B;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// results taken from the registered product
	always_comb begin
		fxy_sum = 17'(cfg.speed_xy_low) + 17'(prod_q[31:16]);
		frot_sum = 17'(cfg.speed_rot_low) + 17'(prod_q[31:16]);
		fxy_new = (cfg.speed_xy_low > cfg.speed_xy_high) ? cfg.speed_xy_high : fxy_sum[15:0];
		frot_new = (cfg.speed_rot_low > cfg.speed_rot_high) ? cfg.speed_rot_high
			: frot_sum[15:0];
		g_wide = 18'sd32768 - signed'({2'b00, prod_q[30:15]});
		t_shape = shr_tz(prod_q, 15);
		s_new = cur_ax.neg ? 17'(-t_shape) : 17'(t_shape);
		t_scale = shr_tz(prod_q, 8);
		if (t_scale > PROD_W'(8388607)) begin
			c_new = 24'sh7fffff;
		end else if (t_scale < -PROD_W'(8388608)) begin
			c_new = 24'sh800000;
		end else begin
			c_new = t_scale[23:0];
		end
		t_filt = shr_tz(prod_q, 16);
		filt_new = cur_filt + 24'(t_filt);
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		div_req.start = 1'b0;
		div_req.diff = cur_ax.diff;
		div_req.den = cur_den;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					state_d = ST_FXY;
				end
			end
			ST_FXY: state_d = ST_FXY_W;
			ST_FXY_W: state_d = ST_FROT;
			ST_FROT: state_d = ST_FROT_W;
			ST_FROT_W: state_d = ST_DIV;
			ST_DIV: begin
				if (cur_ax.dead) begin
					state_d = ST_SCALE;
				end else begin
					div_req.start = 1'b1;
					state_d = ST_DIV_W;
				end
			end
			ST_DIV_W: begin
				if (div_rsp.done) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: state_d = ST_GAIN_W;
			ST_GAIN_W: state_d = ST_SHAPE;
			ST_SHAPE: state_d = ST_SHAPE_W;
			ST_SHAPE_W: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_SCALE_W;
			ST_SCALE_W: state_d = ST_FILT;
			ST_FILT: state_d = ST_FILT_W;
			ST_FILT_W: state_d = last_ax ? ST_OUT : ST_DIV;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// axis index, filter state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= AX_X;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_AX; i++) begin
				filt_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_IDLE) begin
				ax_q <= AX_X;
			end else if (state_q == ST_FILT_W && !last_ax) begin
				ax_q <= ax_q + 2'd1;
			end
			if (state_q == ST_FILT_W) begin
				for (int i = 0; i < NUM_AX; i++) begin
					if (ax_q == ax_idx_t'(i)) begin
						filt_q[i] <= filt_new;
					end
				end
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (pop) begin
			work_q <= rd_data;
		end
		case (state_q)
			ST_FXY_W: fxy_q <= fxy_new;
			ST_FROT_W: frot_q <= frot_new;
			ST_DIV: begin
				if (cur_ax.dead) begin
					s_q <= '0;
				end
			end
			ST_DIV_W: begin
				if (div_rsp.done) begin
					m_q <= div_rsp.quot;
				end
			end
			ST_GAIN_W: g_q <= g_wide[16:0];
			ST_SHAPE_W: s_q <= s_new;
			ST_SCALE_W: c_q <= c_new;
			ST_OUT: begin
				if (out_free) begin
					out_data_q.cmd_x <= filt_q[AX_X];
					out_data_q.cmd_y <= filt_q[AX_Y];
					out_data_q.cmd_rot <= filt_q[AX_ROT];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_data_q;

endmodule

/* sv/joystick_axis_conditioner.sv */
// channel   dir  handshake      payload
// in_ch     in   valid/ready    axis_fore, axis_side, axis_throttle, axis_twist (16b signed)
// out_ch    out  valid/ready    cmd_x, cmd_y, cmd_rot (24b signed)
// apb       in   psel/penable   eight config registers at 4*index, pready tied high
//
// an item gets xy and rot speed factors, then per axis divide, gain, shape, scale, filter;
// dead axes skip to scale; shared one-bit-a-cycle divider and single multiplier
// reset loads the register defaults, clears the filter state and empties the queue
// input stalls only when the work queue is full; the back end stalls only while
// a finished result waits in the output register
module joystick_axis_conditioner #(
	parameter int FILTER_ALPHA_Q16 = 65536,
	parameter int QUEUE_DEPTH      = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	jac_in_if.sink                      in_ch,
	jac_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [jac_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import jac_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_empty;
	work_t    wr_data;
	work_t    rd_data;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband_xy <= DEADBAND_RST;
			cfg_q.slope_xy <= SLOPE_RST;
			cfg_q.deadband_rot <= DEADBAND_RST;
			cfg_q.slope_rot <= SLOPE_RST;
			cfg_q.speed_xy_high <= SPEED_HI_RST;
			cfg_q.speed_xy_low <= SPEED_LO_RST;
			cfg_q.speed_rot_high <= SPEED_HI_RST;
			cfg_q.speed_rot_low <= SPEED_LO_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DEADBAND_XY: cfg_q.deadband_xy <= pwdata[14:0];
				REG_SLOPE_XY: cfg_q.slope_xy <= pwdata[15:0];
				REG_DEADBAND_ROT: cfg_q.deadband_rot <= pwdata[14:0];
				REG_SLOPE_ROT: cfg_q.slope_rot <= pwdata[15:0];
				REG_SPEED_XY_HIGH: cfg_q.speed_xy_high <= pwdata[15:0];
				REG_SPEED_XY_LOW: cfg_q.speed_xy_low <= pwdata[15:0];
				REG_SPEED_ROT_HIGH: cfg_q.speed_rot_high <= pwdata[15:0];
				REG_SPEED_ROT_LOW: cfg_q.speed_rot_low <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_DEADBAND_XY: prdata = 32'(cfg_q.deadband_xy);
			REG_SLOPE_XY: prdata = 32'(cfg_q.slope_xy);
			REG_DEADBAND_ROT: prdata = 32'(cfg_q.deadband_rot);
			REG_SLOPE_ROT: prdata = 32'(cfg_q.slope_rot);
			REG_SPEED_XY_HIGH: prdata = 32'(cfg_q.speed_xy_high);
			REG_SPEED_XY_LOW: prdata = 32'(cfg_q.speed_xy_low);
			REG_SPEED_ROT_HIGH: prdata = 32'(cfg_q.speed_rot_high);
			REG_SPEED_ROT_LOW: prdata = 32'(cfg_q.speed_rot_low);
			default: prdata = '0;
		endcase
	end

	jac_front u_front (
		.cfg    (cfg_q),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.work   (wr_data)
	);

	jac_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_data),
		.pop     (pop),
		.rd_data (rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	jac_back #(
		.FILTER_ALPHA_Q16 (FILTER_ALPHA_Q16)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.rd_data (rd_data),
		.q_empty (q_empty),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

/* sv/jac_checker.sv */
module jac_checker #(
	parameter int DEPTH = 2
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input jac_pkg::out_item_t out_data
);
	import jac_pkg::*;

	localparam int MAX_PEND = DEPTH + 2;
	localparam int PEND_W   = $clog2(MAX_PEND + 1);

	logic              in_acc;
	logic              out_acc;
	logic [PEND_W-1:0] pend_q;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + PEND_W'(1);
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - PEND_W'(1);
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// no result without an outstanding transaction
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result with no transaction outstanding");

	// queue, work register and output register bound the outstanding count
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(MAX_PEND))
		else $error("too many transactions outstanding");

	// empty block always takes input
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == '0 |-> in_ready)
		else $error("input stalled while block is empty");

	// a result cannot follow its transaction in the next cycle
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == '0 && in_acc |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind joystick_axis_conditioner jac_checker #(
	.DEPTH (QUEUE_DEPTH)
) u_jac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

/* verif/joystick_axis_conditioner_tb.sv */
`timescale 1ns / 100ps

module joystick_axis_conditioner_tb;
	import jac_pkg::*;

	localparam int LPF_ALPHA_Q16   = 65536;
	localparam int CYCLE_LIMIT     = 1500000;
	localparam int NUM_PHASES      = 14;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int DRAIN_CYCLES    = 100;
	localparam int DIR_ROWS        = 15;

	// register sets used by the directed rows
	typedef enum logic [1:0] {
		CFG_RESET,
		CFG_UNITY,
		CFG_HARSH
	} cfg_set_t;

	typedef struct packed {
		cfg_set_t  sel;
		in_item_t  axes;
		logic      typed;
		out_item_t want;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	jac_in_if  in_ch ();
	jac_out_if out_ch ();

	joystick_axis_conditioner #(
		.FILTER_ALPHA_Q16(LPF_ALPHA_Q16)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// register mirror and filter state of the predictor
	cfg_t               cfg_mirror;
	logic signed [23:0] lp_x;
	logic signed [23:0] lp_y;
	logic signed [23:0] lp_rot;

	out_item_t pending_cmds [$];
	int        fail_count;
	int        cycle_count;
	bit        src_burst;
	bit        snk_burst;

	// directed rows: typed results only where they follow at a glance
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{CFG_RESET, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{24'sd0, 24'sd0, 24'sd0}},
		'{CFG_RESET, '{-16'sd3277, 16'sd3277, 16'sh7fff, -16'sd3277}, 1'b1,
			'{24'sd0, 24'sd0, 24'sd0}},
		'{CFG_RESET, '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000}, 1'b0, '0},
		'{CFG_RESET, '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
		'{CFG_RESET, '{-16'sd3278, -16'sd3278, 16'sd0, 16'sd3278}, 1'b0, '0},
		'{CFG_RESET, '{16'sh1234, -16'sd20000, -16'sd1, 16'sh4321}, 1'b0, '0},
		'{CFG_UNITY, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff}, 1'b1,
			'{24'sd32767, -24'sd32768, 24'sd32767}},
		'{CFG_UNITY, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000}, 1'b1,
			'{-24'sd32767, 24'sd32767, -24'sd32768}},
		'{CFG_UNITY, '{16'sd1, -16'sd1, 16'sd0, 16'sd1}, 1'b1, '{-24'sd1, -24'sd1, 24'sd1}},
		'{CFG_UNITY, '{16'sd0, 16'sd0, 16'sh1234, 16'sd0}, 1'b1, '{24'sd0, 24'sd0, 24'sd0}},
		'{CFG_UNITY, '{16'sh5555, 16'shaaaa, 16'sh2aaa, 16'sh0f0f}, 1'b1,
			'{-24'sd21845, -24'sd21846, 24'sd3855}},
		'{CFG_HARSH, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
		'{CFG_HARSH, '{-16'sd256, 16'sd1000, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
		'{CFG_HARSH, '{16'sd0, -16'sd5000, 16'sd0, 16'sh8000}, 1'b0, '0},
		'{CFG_HARSH, '{16'sh7ffe, 16'sh0100, -16'sd12345, 16'sh8001}, 1'b0, '0}
	};

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// arithmetic shift right rounding toward zero
	function automatic longint asr_to_zero(longint v, int n);
		if (v >= 0)
			return v >>> n;
		return -((-v) >>> n);
	endfunction

	// deadband, rescale and quadratic curve of one axis
	function automatic int curve_axis(int r, logic [14:0] dband, logic [15:0] slope);
		longint mag, d, m, g, s;
		mag = (r < 0) ? -longint'(r) : longint'(r);
		d = longint'(dband);
		if (mag <= d)
			return 0;
		m = ((mag - d) * 32768) / (32768 - d);
		g = 32768 - ((longint'(slope) * (32768 - m)) >>> 15);
		s = asr_to_zero(g * m, 15);
		return int'((r < 0) ? -s : s);
	endfunction

	// throttle picks a factor between low and high, high wins when inverted
	function automatic longint speed_scale(int z, logic [15:0] lo, logic [15:0] hi);
		longint k16;
		k16 = 32768 - longint'(z);
		if (lo > hi)
			return longint'(hi);
		return longint'(lo) + (((longint'(hi) - longint'(lo)) * k16) >>> 16);
	endfunction

	// scale by speed factor and saturate to 24 bits
	function automatic int apply_speed(int s, longint f);
		longint c;
		c = asr_to_zero(longint'(s) * f, 8);
		if (c > 8388607)
			c = 8388607;
		if (c < -8388608)
			c = -8388608;
		return int'(c);
	endfunction

	function automatic logic signed [23:0] lowpass(logic signed [23:0] st, int cmd);
		longint diff;
		diff = longint'(cmd) - longint'(st);
		return 24'(longint'(st) + asr_to_zero(diff * LPF_ALPHA_Q16, 16));
	endfunction

	// advance the predicted filters by one stick sample
	function automatic out_item_t next_commands(in_item_t ax);
		int        fore, fore_n, sx, sy, sr;
		longint    f_xy, f_rot;
		out_item_t res;
		fore = $signed(ax.axis_fore);
		fore_n = (fore == -32768) ? 32767 : -fore;
		sx = curve_axis(fore_n, cfg_mirror.deadband_xy, cfg_mirror.slope_xy);
		sy = curve_axis($signed(ax.axis_side), cfg_mirror.deadband_xy, cfg_mirror.slope_xy);
		sr = curve_axis($signed(ax.axis_twist), cfg_mirror.deadband_rot, cfg_mirror.slope_rot);
		f_xy = speed_scale($signed(ax.axis_throttle), cfg_mirror.speed_xy_low,
			cfg_mirror.speed_xy_high);
		f_rot = speed_scale($signed(ax.axis_throttle), cfg_mirror.speed_rot_low,
			cfg_mirror.speed_rot_high);
		lp_x = lowpass(lp_x, apply_speed(sx, f_xy));
		lp_y = lowpass(lp_y, apply_speed(sy, f_xy));
		lp_rot = lowpass(lp_rot, apply_speed(sr, f_rot));
		res.cmd_x = lp_x;
		res.cmd_y = lp_y;
		res.cmd_rot = lp_rot;
		return res;
	endfunction

	function automatic logic [31:0] reg_value(reg_idx_t idx);
		case (idx)
			REG_DEADBAND_XY:    return {17'd0, cfg_mirror.deadband_xy};
			REG_SLOPE_XY:       return {16'd0, cfg_mirror.slope_xy};
			REG_DEADBAND_ROT:   return {17'd0, cfg_mirror.deadband_rot};
			REG_SLOPE_ROT:      return {16'd0, cfg_mirror.slope_rot};
			REG_SPEED_XY_HIGH:  return {16'd0, cfg_mirror.speed_xy_high};
			REG_SPEED_XY_LOW:   return {16'd0, cfg_mirror.speed_xy_low};
			REG_SPEED_ROT_HIGH: return {16'd0, cfg_mirror.speed_rot_high};
			default:            return {16'd0, cfg_mirror.speed_rot_low};
		endcase
	endfunction

	function automatic cfg_t config_set(cfg_set_t sel);
		cfg_t c;
		c = '0;
		case (sel)
			CFG_RESET: begin
				c.deadband_xy = DEADBAND_RST;
				c.slope_xy = SLOPE_RST;
				c.deadband_rot = DEADBAND_RST;
				c.slope_rot = SLOPE_RST;
				c.speed_xy_high = SPEED_HI_RST;
				c.speed_xy_low = SPEED_LO_RST;
				c.speed_rot_high = SPEED_HI_RST;
				c.speed_rot_low = SPEED_LO_RST;
			end
			CFG_UNITY: begin
				c.speed_xy_high = 16'd256;
				c.speed_xy_low = 16'd256;
				c.speed_rot_high = 16'd256;
				c.speed_rot_low = 16'd256;
			end
			default: begin
				// negative gain on xy, low above high on xy, full range on rot
				c.slope_xy = 16'hffff;
				c.deadband_rot = 15'h7fff;
				c.slope_rot = 16'd32768;
				c.speed_xy_high = 16'd100;
				c.speed_xy_low = 16'hffff;
				c.speed_rot_high = 16'hffff;
			end
		endcase
		return c;
	endfunction

	function automatic int pick_reg(int top, int typical, int rst);
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return top;
			2:       return rst;
			3, 4, 5: return $urandom_range(0, typical);
			default: return $urandom_range(0, top);
		endcase
	endfunction

	// first two phases sit at the extremes, the rest are mixed
	function automatic cfg_t random_config(int ph);
		cfg_t c;
		if (ph == 0)
			return '1;
		if (ph == 1)
			return '0;
		c.deadband_xy = 15'(pick_reg(32767, 8192, int'(DEADBAND_RST)));
		c.slope_xy = 16'(pick_reg(65535, 32768, int'(SLOPE_RST)));
		c.deadband_rot = 15'(pick_reg(32767, 8192, int'(DEADBAND_RST)));
		c.slope_rot = 16'(pick_reg(65535, 32768, int'(SLOPE_RST)));
		c.speed_xy_high = 16'(pick_reg(65535, 1024, int'(SPEED_HI_RST)));
		c.speed_xy_low = 16'(pick_reg(65535, 1024, int'(SPEED_LO_RST)));
		c.speed_rot_high = 16'(pick_reg(65535, 1024, int'(SPEED_HI_RST)));
		c.speed_rot_low = 16'(pick_reg(65535, 1024, int'(SPEED_LO_RST)));
		return c;
	endfunction

	// axis value biased to full scale, zero and the deadband edge
	function automatic logic [15:0] random_axis(logic [14:0] dband);
		int mag;
		case ($urandom_range(0, 15))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       mag = $urandom_range(0, 3);
			4, 5:    mag = int'(dband) + int'($urandom_range(0, 4)) - 2;
			default: return 16'($urandom);
		endcase
		if (mag < 0)
			mag = 0;
		if (mag > 32767)
			mag = 32767;
		return ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
	endfunction

	function automatic in_item_t random_axes();
		in_item_t it;
		it.axis_fore = random_axis(cfg_mirror.deadband_xy);
		it.axis_side = random_axis(cfg_mirror.deadband_xy);
		it.axis_twist = random_axis(cfg_mirror.deadband_rot);
		case ($urandom_range(0, 7))
			0:       it.axis_throttle = 16'sh8000;
			1:       it.axis_throttle = 16'sh7fff;
			2:       it.axis_throttle = 16'sd0;
			default: it.axis_throttle = 16'($urandom);
		endcase
		return it;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// apb write, then read back
	task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = PADDR_W'({idx, 2'b00});
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DEADBAND_XY:    cfg_mirror.deadband_xy = val[14:0];
			REG_SLOPE_XY:       cfg_mirror.slope_xy = val[15:0];
			REG_DEADBAND_ROT:   cfg_mirror.deadband_rot = val[14:0];
			REG_SLOPE_ROT:      cfg_mirror.slope_rot = val[15:0];
			REG_SPEED_XY_HIGH:  cfg_mirror.speed_xy_high = val[15:0];
			REG_SPEED_XY_LOW:   cfg_mirror.speed_xy_low = val[15:0];
			REG_SPEED_ROT_HIGH: cfg_mirror.speed_rot_high = val[15:0];
			default:            cfg_mirror.speed_rot_low = val[15:0];
		endcase
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== reg_value(idx)) begin
			fail_count++;
			$display("%0t: register %s read expected %0h, got %0h", $time, idx.name(),
				reg_value(idx), prdata);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic load_config(cfg_t c);
		cfg_write(REG_DEADBAND_XY, {17'd0, c.deadband_xy});
		cfg_write(REG_SLOPE_XY, {16'd0, c.slope_xy});
		cfg_write(REG_DEADBAND_ROT, {17'd0, c.deadband_rot});
		cfg_write(REG_SLOPE_ROT, {16'd0, c.slope_rot});
		cfg_write(REG_SPEED_XY_HIGH, {16'd0, c.speed_xy_high});
		cfg_write(REG_SPEED_XY_LOW, {16'd0, c.speed_xy_low});
		cfg_write(REG_SPEED_ROT_HIGH, {16'd0, c.speed_rot_high});
		cfg_write(REG_SPEED_ROT_LOW, {16'd0, c.speed_rot_low});
	endtask

	// one input transaction, expectation queued on acceptance
	task automatic send_axes(in_item_t axes, bit typed, out_item_t want);
		out_item_t pred;
		int        gap;
		gap = pick_gap(src_burst);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = axes;
		do @(posedge clk); while (!in_ch.ready);
		pred = next_commands(axes);
		pending_cmds.push_back(typed ? want : pred);
	endtask

	task automatic release_input();
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string label, logic signed [23:0] want,
		logic signed [23:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
		end
	endtask

	// output side: random stalls on ready
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				stall--;
			end else begin
				out_ch.ready = 1'b1;
				stall = ($urandom_range(0, 2) == 0) ? pick_gap(snk_burst) : 0;
			end
		end
	end

	// compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		out_item_t exp_cmd;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_cmds.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, expected none, got %0d %0d %0d", $time,
					out_ch.data.cmd_x, out_ch.data.cmd_y, out_ch.data.cmd_rot);
			end else begin
				exp_cmd = pending_cmds.pop_front();
				check_field("cmd_x", exp_cmd.cmd_x, out_ch.data.cmd_x);
				check_field("cmd_y", exp_cmd.cmd_y, out_ch.data.cmd_y);
				check_field("cmd_rot", exp_cmd.cmd_rot, out_ch.data.cmd_rot);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("joystick_axis_conditioner_tb failed");
			$finish;
		end
	end

	// main sequence
	initial begin
		cfg_set_t cur;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		fail_count = 0;
		cycle_count = 0;
		src_burst = 1'b0;
		snk_burst = 1'b0;
		cfg_mirror = config_set(CFG_RESET);
		lp_x = '0;
		lp_y = '0;
		lp_rot = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows, first ones on the reset register values
		cur = CFG_RESET;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].sel != cur) begin
				release_input();
				wait_drained();
				cur = dir_rows[i].sel;
				load_config(config_set(cur));
			end
			send_axes(dir_rows[i].axes, dir_rows[i].typed, dir_rows[i].want);
		end
		release_input();

		// random phases, each with its own register setting and idling mode
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			load_config(random_config(ph));
			src_burst = ($urandom_range(0, 3) == 0);
			snk_burst = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_axes(random_axes(), 1'b0, '0);
			release_input();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("joystick_axis_conditioner_tb passed");
		else
			$display("joystick_axis_conditioner_tb failed");
		$finish;
	end

endmodule

/* files.f */
sv/jac_pkg.sv
sv/jac_if.sv
sv/jac_front.sv
sv/jac_queue.sv
sv/jac_div.sv
sv/jac_back.sv
sv/joystick_axis_conditioner.sv
sv/jac_checker.sv
verif/joystick_axis_conditioner_tb.sv
